[rtl/ssv_pkg.sv]
`timescale 1ns / 1ps
// ssv_pkg: phase type, byte roles, value kinds and status codes of the
// snapshot stream validator; no dependencies

package ssv_pkg;

   typedef enum logic [3:0] {
      PH_MAGIC = 4'd0,
      PH_COLS  = 4'd1,
      PH_ROWS  = 4'd2,
      PH_KIND  = 4'd3,
      PH_TLEN  = 4'd4,
      PH_TEXT  = 4'd5,
      PH_REAL  = 4'd6,
      PH_INT   = 4'd7,
      PH_DONE  = 4'd8
   } phase_type;

   // byte roles
   localparam logic [3:0] ROLE_MAGIC   = 4'd0;
   localparam logic [3:0] ROLE_COLS    = 4'd1;
   localparam logic [3:0] ROLE_ROWS    = 4'd2;
   localparam logic [3:0] ROLE_KIND    = 4'd3;
   localparam logic [3:0] ROLE_TLEN    = 4'd4;
   localparam logic [3:0] ROLE_TEXT    = 4'd5;
   localparam logic [3:0] ROLE_REAL    = 4'd6;
   localparam logic [3:0] ROLE_INT     = 4'd7;
   localparam logic [3:0] ROLE_IGNORED = 4'd8;

   // value kinds
   localparam logic [1:0] KIND_NULL = 2'd0;
   localparam logic [1:0] KIND_TEXT = 2'd1;
   localparam logic [1:0] KIND_REAL = 2'd2;
   localparam logic [1:0] KIND_INT  = 2'd3;

   // status codes
   localparam logic [2:0] ST_PENDING  = 3'd0;
   localparam logic [2:0] ST_OK       = 3'd1;
   localparam logic [2:0] ST_MAGIC    = 3'd2;
   localparam logic [2:0] ST_COLS     = 3'd3;
   localparam logic [2:0] ST_ROWS     = 3'd4;
   localparam logic [2:0] ST_KIND     = 3'd5;
   localparam logic [2:0] ST_VALUE    = 3'd6;
   localparam logic [2:0] ST_TRAILING = 3'd7;

   // 'R','A','S','1' packed little-endian, byte n at bits 8n+7:8n
   localparam logic [31:0] MAGIC_WORD = 32'h3153_4152;

   localparam int unsigned MAX_COLUMNS = 256;

   localparam logic [10:0] EXP_ALL_ONES = 11'h7FF;
   localparam logic [8:0]  COLS_RESET   = 9'd16;

endpackage

[rtl/snapshot_stream_validator_unit.sv]
`timescale 1ns / 1ps
// snapshot_stream_validator_unit: byte-serial layout checker for snapshot payloads
// depends on ssv_pkg
//
// usage
//   req channel: one payload byte per transaction, req_last_byte marks the final
//   byte; after it all parsing state restarts for the next payload
//   rsp channel: exactly one transaction per request byte, carrying the byte's
//   role, value kind, column, row and the running status
//   csr channel: writes expected_columns; always ready, write only while idle
// latency and throughput
//   response valid in the cycle after request acceptance; one byte per cycle
//   sustained while rsp_ready stays high, set by the single next-state stage feeding the response register
// reset
//   synchronous, active high; parser returns to the magic phase, no error kept,
//   expected_columns returns to 16, no response pending
// stall
//   when the receiver holds rsp_ready low with a response pending, req_ready
//   drops in the same cycle; no byte is lost or duplicated
// the first error is kept and reported on every later byte up to the last one;
// on the last byte an unfinished payload reports the error of its phase

module snapshot_stream_validator_unit #(
   parameter int unsigned MAX_ROWS = 1000000
) (
   input  logic        clock,
   input  logic        reset,
   // request byte stream
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   // response stream
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_byte_role,
   output logic [1:0]  rsp_value_kind,
   output logic [7:0]  rsp_column_index,
   output logic [19:0] rsp_row_index,
   output logic [2:0]  rsp_status,
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [8:0]  csr_expected_columns
);

   localparam int unsigned ROW_W = $clog2(MAX_ROWS + 1);

   // parser state
   ssv_pkg::phase_type phase_ff, phase_in;
   logic [2:0]         cnt_ff, cnt_in;
   logic [31:0]        hword_ff, hword_in;
   logic [8:0]         col_total_ff, col_total_in;
   logic [ROW_W-1:0]   row_total_ff, row_total_in;
   logic [ROW_W-1:0]   cur_row_ff, cur_row_in;
   logic [7:0]         cur_col_ff, cur_col_in;
   logic [31:0]        text_rem_ff, text_rem_in;
   logic [10:0]        exp_ff, exp_in;
   logic [2:0]         err_ff, err_in;
   logic [8:0]         exp_cols_ff;

   // response register
   logic               rsp_valid_ff;
   logic [3:0]         role_ff, role_in;
   logic [1:0]         kind_ff, kind_in;
   logic [7:0]         col_ff, col_in;
   logic [19:0]        row_ff, row_in;
   logic [2:0]         status_ff, status_in;

   logic               accept;

   // header word with this byte merged in
   logic [31:0]        hword_next;
   logic [31:0]        byte_shifted;
   logic [7:0]         magic_byte;

   // end of value bookkeeping
   logic [8:0]         col_plus;
   logic [ROW_W:0]     row_plus;
   logic               col_wrap;
   logic [7:0]         fin_col;
   logic [ROW_W-1:0]   fin_row;
   ssv_pkg::phase_type fin_phase;

   logic [10:0]        exp_next;
   logic [31:0]        text_rem_dec;
   logic [31:0]        row_wide;

   // response register is empty or drains in this cycle
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign byte_shifted = {24'd0, req_data_byte} << {cnt_ff[1:0], 3'b000};
   assign hword_next   = hword_ff | byte_shifted;
   assign magic_byte   = ssv_pkg::MAGIC_WORD[{cnt_ff[1:0], 3'b000} +: 8];
   assign text_rem_dec = text_rem_ff - 32'd1;

   // exponent of a real: high nibble of byte 6, low 7 bits of byte 7
   always_comb begin
      exp_next = exp_ff;
      if (cnt_ff == 3'd6) begin
         exp_next = {7'd0, req_data_byte[7:4]};
      end else if (cnt_ff == 3'd7) begin
         exp_next = exp_ff | {req_data_byte[6:0], 4'd0};
      end
   end

   // column/row advance after a value completes
   always_comb begin
      col_plus = {1'b0, cur_col_ff} + 9'd1;
      row_plus = {1'b0, cur_row_ff} + {{ROW_W{1'b0}}, 1'b1};
      col_wrap = col_plus >= col_total_ff;
      if (col_wrap) begin
         fin_col   = 8'd0;
         fin_row   = row_plus[ROW_W-1:0];
         fin_phase = (row_plus >= {1'b0, row_total_ff}) ? ssv_pkg::PH_DONE
                                                        : ssv_pkg::PH_KIND;
      end else begin
         fin_col   = col_plus[7:0];
         fin_row   = cur_row_ff;
         fin_phase = ssv_pkg::PH_KIND;
      end
   end

   // next state of the parser for one byte
   always_comb begin
      phase_in     = phase_ff;
      cnt_in       = cnt_ff;
      hword_in     = hword_ff;
      col_total_in = col_total_ff;
      row_total_in = row_total_ff;
      cur_row_in   = cur_row_ff;
      cur_col_in   = cur_col_ff;
      text_rem_in  = text_rem_ff;
      exp_in       = exp_ff;
      err_in       = err_ff;

      if (err_ff == ssv_pkg::ST_PENDING) begin
         case (phase_ff)
            ssv_pkg::PH_MAGIC: begin
               if (req_data_byte != magic_byte) begin
                  err_in = ssv_pkg::ST_MAGIC;
               end else if (cnt_ff == 3'd3) begin
                  phase_in = ssv_pkg::PH_COLS;
                  cnt_in   = 3'd0;
                  hword_in = 32'd0;
               end else begin
                  cnt_in = cnt_ff + 3'd1;
               end
            end
            ssv_pkg::PH_COLS: begin
               hword_in = hword_next;
               cnt_in   = cnt_ff + 3'd1;
               if (cnt_ff == 3'd3) begin
                  if (hword_next != {23'd0, exp_cols_ff} || hword_next == 32'd0 ||
                      hword_next > 32'(ssv_pkg::MAX_COLUMNS)) begin
                     err_in = ssv_pkg::ST_COLS;
                  end else begin
                     col_total_in = hword_next[8:0];
                     phase_in     = ssv_pkg::PH_ROWS;
                     cnt_in       = 3'd0;
                     hword_in     = 32'd0;
                  end
               end
            end
            ssv_pkg::PH_ROWS: begin
               hword_in = hword_next;
               cnt_in   = cnt_ff + 3'd1;
               if (cnt_ff == 3'd3) begin
                  if (hword_next > 32'(MAX_ROWS)) begin
                     err_in = ssv_pkg::ST_ROWS;
                  end else begin
                     row_total_in = hword_next[ROW_W-1:0];
                     cur_row_in   = '0;
                     cur_col_in   = 8'd0;
                     cnt_in       = 3'd0;
                     hword_in     = 32'd0;
                     phase_in     = (hword_next == 32'd0) ? ssv_pkg::PH_DONE
                                                          : ssv_pkg::PH_KIND;
                  end
               end
            end
            ssv_pkg::PH_KIND: begin
               if (req_data_byte > 8'd3) begin
                  err_in = ssv_pkg::ST_KIND;
               end else begin
                  cnt_in   = 3'd0;
                  hword_in = 32'd0;
                  exp_in   = 11'd0;
                  case (req_data_byte[1:0])
                     ssv_pkg::KIND_NULL: begin
                        phase_in   = fin_phase;
                        cur_col_in = fin_col;
                        cur_row_in = fin_row;
                     end
                     ssv_pkg::KIND_TEXT: phase_in = ssv_pkg::PH_TLEN;
                     ssv_pkg::KIND_REAL: phase_in = ssv_pkg::PH_REAL;
                     default:            phase_in = ssv_pkg::PH_INT;
                  endcase
               end
            end
            ssv_pkg::PH_TLEN: begin
               hword_in = hword_next;
               cnt_in   = cnt_ff + 3'd1;
               if (cnt_ff == 3'd3) begin
                  text_rem_in = hword_next;
                  cnt_in      = 3'd0;
                  hword_in    = 32'd0;
                  if (hword_next == 32'd0) begin
                     phase_in   = fin_phase;
                     cur_col_in = fin_col;
                     cur_row_in = fin_row;
                  end else begin
                     phase_in = ssv_pkg::PH_TEXT;
                  end
               end
            end
            ssv_pkg::PH_TEXT: begin
               text_rem_in = text_rem_dec;
               if (text_rem_dec == 32'd0) begin
                  phase_in   = fin_phase;
                  cur_col_in = fin_col;
                  cur_row_in = fin_row;
               end
            end
            ssv_pkg::PH_REAL: begin
               exp_in = exp_next;
               cnt_in = cnt_ff + 3'd1;
               if (cnt_ff == 3'd7) begin
                  cnt_in = 3'd0;
                  if (exp_next == ssv_pkg::EXP_ALL_ONES) begin
                     err_in = ssv_pkg::ST_VALUE;
                  end else begin
                     phase_in   = fin_phase;
                     cur_col_in = fin_col;
                     cur_row_in = fin_row;
                  end
               end
            end
            ssv_pkg::PH_INT: begin
               cnt_in = cnt_ff + 3'd1;
               if (cnt_ff == 3'd7) begin
                  cnt_in     = 3'd0;
                  phase_in   = fin_phase;
                  cur_col_in = fin_col;
                  cur_row_in = fin_row;
               end
            end
            default: begin
               // any byte past a complete snapshot
               err_in = ssv_pkg::ST_TRAILING;
            end
         endcase
      end

      // status uses the state after this byte, before the end-of-payload restart
      if (req_last_byte) begin
         if (err_in != ssv_pkg::ST_PENDING) begin
            status_in = err_in;
         end else begin
            case (phase_in)
               ssv_pkg::PH_DONE:  status_in = ssv_pkg::ST_OK;
               ssv_pkg::PH_MAGIC: status_in = ssv_pkg::ST_MAGIC;
               ssv_pkg::PH_COLS:  status_in = ssv_pkg::ST_COLS;
               ssv_pkg::PH_ROWS:  status_in = ssv_pkg::ST_ROWS;
               ssv_pkg::PH_KIND:  status_in = ssv_pkg::ST_KIND;
               default:           status_in = ssv_pkg::ST_VALUE;
            endcase
         end
         phase_in     = ssv_pkg::PH_MAGIC;
         cnt_in       = 3'd0;
         hword_in     = 32'd0;
         col_total_in = 9'd0;
         row_total_in = '0;
         cur_row_in   = '0;
         cur_col_in   = 8'd0;
         text_rem_in  = 32'd0;
         exp_in       = 11'd0;
         err_in       = ssv_pkg::ST_PENDING;
      end else begin
         status_in = err_in;
      end
   end

   // per-byte tags, taken from the state before this byte
   assign row_wide = 32'(cur_row_ff);

   always_comb begin
      role_in = ssv_pkg::ROLE_IGNORED;
      kind_in = ssv_pkg::KIND_NULL;
      col_in  = 8'd0;
      row_in  = 20'd0;
      if (err_ff == ssv_pkg::ST_PENDING) begin
         case (phase_ff)
            ssv_pkg::PH_MAGIC: role_in = ssv_pkg::ROLE_MAGIC;
            ssv_pkg::PH_COLS:  role_in = ssv_pkg::ROLE_COLS;
            ssv_pkg::PH_ROWS:  role_in = ssv_pkg::ROLE_ROWS;
            ssv_pkg::PH_KIND: begin
               role_in = ssv_pkg::ROLE_KIND;
               if (req_data_byte <= 8'd3) begin
                  kind_in = req_data_byte[1:0];
               end
            end
            ssv_pkg::PH_TLEN: begin
               role_in = ssv_pkg::ROLE_TLEN;
               kind_in = ssv_pkg::KIND_TEXT;
            end
            ssv_pkg::PH_TEXT: begin
               role_in = ssv_pkg::ROLE_TEXT;
               kind_in = ssv_pkg::KIND_TEXT;
            end
            ssv_pkg::PH_REAL: begin
               role_in = ssv_pkg::ROLE_REAL;
               kind_in = ssv_pkg::KIND_REAL;
            end
            ssv_pkg::PH_INT: begin
               role_in = ssv_pkg::ROLE_INT;
               kind_in = ssv_pkg::KIND_INT;
            end
            default: role_in = ssv_pkg::ROLE_IGNORED;
         endcase
         // column and row only inside the value section
         if (phase_ff == ssv_pkg::PH_KIND || phase_ff == ssv_pkg::PH_TLEN ||
             phase_ff == ssv_pkg::PH_TEXT || phase_ff == ssv_pkg::PH_REAL ||
             phase_ff == ssv_pkg::PH_INT) begin
            col_in = cur_col_ff;
            row_in = row_wide[19:0];
         end
      end
   end

   // parser state and configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= ssv_pkg::PH_MAGIC;
         cnt_ff       <= 3'd0;
         hword_ff     <= 32'd0;
         col_total_ff <= 9'd0;
         row_total_ff <= '0;
         cur_row_ff   <= '0;
         cur_col_ff   <= 8'd0;
         text_rem_ff  <= 32'd0;
         exp_ff       <= 11'd0;
         err_ff       <= ssv_pkg::ST_PENDING;
         exp_cols_ff  <= ssv_pkg::COLS_RESET;
      end else begin
         if (accept) begin
            phase_ff     <= phase_in;
            cnt_ff       <= cnt_in;
            hword_ff     <= hword_in;
            col_total_ff <= col_total_in;
            row_total_ff <= row_total_in;
            cur_row_ff   <= cur_row_in;
            cur_col_ff   <= cur_col_in;
            text_rem_ff  <= text_rem_in;
            exp_ff       <= exp_in;
            err_ff       <= err_in;
         end
         if (csr_valid && csr_ready) begin
            exp_cols_ff <= csr_expected_columns;
         end
      end
   end

   // response valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // response payload, loaded with each accepted byte
   always_ff @(posedge clock) begin
      if (accept) begin
         role_ff   <= role_in;
         kind_ff   <= kind_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         status_ff <= status_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_byte_role    = role_ff;
   assign rsp_value_kind   = kind_ff;
   assign rsp_column_index = col_ff;
   assign rsp_row_index    = row_ff;
   assign rsp_status       = status_ff;

endmodule

[test/snapshot_stream_validator_unit_tb.sv]
`timescale 1ns / 1ps
// snapshot_stream_validator_unit_tb: self-checking bench for the snapshot stream validator
// depends on ssv_pkg and snapshot_stream_validator_unit; drives random and directed payloads

module snapshot_stream_validator_unit_tb;

   localparam int unsigned MAX_ROWS       = 1000000;
   localparam int unsigned WATCHDOG_LIMIT = 2000;

   // expected tags of one byte, laid out like the response ports
   typedef struct packed {
      logic [3:0]  role;
      logic [1:0]  kind;
      logic [7:0]  column;
      logic [19:0] row;
      logic [2:0]  status;
   } byte_tag_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'd0;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b1;
   logic [3:0]  rsp_byte_role;
   logic [1:0]  rsp_value_kind;
   logic [7:0]  rsp_column_index;
   logic [19:0] rsp_row_index;
   logic [2:0]  rsp_status;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [8:0]  csr_expected_columns = 9'd0;

   // idling controls, switched off for the last part of the run
   bit sender_idles = 1'b1;
   bit receiver_stalls = 1'b1;

   // payload under construction, sent byte by byte
   logic [7:0] payload[$];

   // tags still owed by the block, oldest first
   byte_tag_type expected_tags[$];
   int unsigned mismatches = 0;
   int unsigned accepted_bytes = 0;
   int unsigned quiet_cycles = 0;

   // parser copy kept by the bench
   ssv_pkg::phase_type ph;
   int unsigned fcount, hword, col_total, row_total, cur_row, cur_col, text_left, exp_bits;
   logic [2:0]  kept;
   logic [8:0]  cfg_columns;

   always #4 clock = ~clock;

   snapshot_stream_validator_unit #(
      .MAX_ROWS(MAX_ROWS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data_byte(req_data_byte),
      .req_last_byte(req_last_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_byte_role(rsp_byte_role),
      .rsp_value_kind(rsp_value_kind),
      .rsp_column_index(rsp_column_index),
      .rsp_row_index(rsp_row_index),
      .rsp_status(rsp_status),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_expected_columns(csr_expected_columns)
   );

   // ---------------------------------------------------------------- parser copy

   function automatic void clear_parser();
      ph        = ssv_pkg::PH_MAGIC;
      fcount    = 0;
      hword     = 0;
      col_total = 0;
      row_total = 0;
      cur_row   = 0;
      cur_col   = 0;
      text_left = 0;
      exp_bits  = 0;
      kept      = ssv_pkg::ST_PENDING;
   endfunction

   // step to the next column, wrapping into the next row or the end of the snapshot
   function automatic void next_value();
      int unsigned c;
      c = cur_col + 1;
      if (c >= col_total) begin
         cur_col = 0;
         cur_row = cur_row + 1;
         ph = (cur_row >= row_total) ? ssv_pkg::PH_DONE : ssv_pkg::PH_KIND;
      end else begin
         cur_col = c;
         ph = ssv_pkg::PH_KIND;
      end
   endfunction

   // little-endian accumulate of a 32-bit header field
   function automatic void take_header(input logic [7:0] b);
      hword = hword | (32'(b) << (8 * (fcount & 3)));
      fcount = fcount + 1;
   endfunction

   // tags of one accepted byte; advances the parser copy
   function automatic byte_tag_type tag_byte(input logic [7:0] b, input logic lst);
      byte_tag_type t;
      t = '0;
      t.role = ssv_pkg::ROLE_IGNORED;
      if (kept == ssv_pkg::ST_PENDING) begin
         // column and row only belong to bytes inside a value
         if (ph >= ssv_pkg::PH_KIND && ph <= ssv_pkg::PH_INT) begin
            t.column = cur_col[7:0];
            t.row    = cur_row[19:0];
         end
         case (ph)
            ssv_pkg::PH_MAGIC: begin
               t.role = ssv_pkg::ROLE_MAGIC;
               if (b != ssv_pkg::MAGIC_WORD[8 * (fcount & 3) +: 8]) begin
                  kept = ssv_pkg::ST_MAGIC;
               end else begin
                  fcount = fcount + 1;
                  if (fcount >= 4) begin
                     ph = ssv_pkg::PH_COLS;
                     fcount = 0;
                     hword = 0;
                  end
               end
            end
            ssv_pkg::PH_COLS: begin
               t.role = ssv_pkg::ROLE_COLS;
               take_header(b);
               if (fcount >= 4) begin
                  // a register of 0 or above the column limit can never match
                  if (hword != cfg_columns || hword == 0 ||
                      hword > ssv_pkg::MAX_COLUMNS) begin
                     kept = ssv_pkg::ST_COLS;
                  end else begin
                     col_total = hword;
                     ph = ssv_pkg::PH_ROWS;
                     fcount = 0;
                     hword = 0;
                  end
               end
            end
            ssv_pkg::PH_ROWS: begin
               t.role = ssv_pkg::ROLE_ROWS;
               take_header(b);
               if (fcount >= 4) begin
                  if (hword > MAX_ROWS) begin
                     kept = ssv_pkg::ST_ROWS;
                  end else begin
                     row_total = hword;
                     cur_row = 0;
                     cur_col = 0;
                     fcount = 0;
                     hword = 0;
                     // zero rows means the snapshot is already complete
                     ph = (row_total == 0) ? ssv_pkg::PH_DONE : ssv_pkg::PH_KIND;
                  end
               end
            end
            ssv_pkg::PH_KIND: begin
               t.role = ssv_pkg::ROLE_KIND;
               if (b > 8'd3) begin
                  kept = ssv_pkg::ST_KIND;
               end else begin
                  t.kind = b[1:0];
                  fcount = 0;
                  hword = 0;
                  exp_bits = 0;
                  case (b[1:0])
                     ssv_pkg::KIND_NULL: next_value();
                     ssv_pkg::KIND_TEXT: ph = ssv_pkg::PH_TLEN;
                     ssv_pkg::KIND_REAL: ph = ssv_pkg::PH_REAL;
                     default:            ph = ssv_pkg::PH_INT;
                  endcase
               end
            end
            ssv_pkg::PH_TLEN: begin
               t.role = ssv_pkg::ROLE_TLEN;
               t.kind = ssv_pkg::KIND_TEXT;
               take_header(b);
               if (fcount >= 4) begin
                  text_left = hword;
                  fcount = 0;
                  hword = 0;
                  if (text_left == 0) next_value();
                  else ph = ssv_pkg::PH_TEXT;
               end
            end
            ssv_pkg::PH_TEXT: begin
               t.role = ssv_pkg::ROLE_TEXT;
               t.kind = ssv_pkg::KIND_TEXT;
               text_left = text_left - 1;
               if (text_left == 0) next_value();
            end
            ssv_pkg::PH_REAL: begin
               t.role = ssv_pkg::ROLE_REAL;
               t.kind = ssv_pkg::KIND_REAL;
               // exponent sits in the top nibble of byte 6 and low 7 bits of byte 7
               if (fcount == 6) exp_bits = 32'(b[7:4]);
               else if (fcount == 7) exp_bits = exp_bits | (32'(b[6:0]) << 4);
               fcount = fcount + 1;
               if (fcount >= 8) begin
                  fcount = 0;
                  if (exp_bits == 32'(ssv_pkg::EXP_ALL_ONES)) kept = ssv_pkg::ST_VALUE;
                  else next_value();
               end
            end
            ssv_pkg::PH_INT: begin
               t.role = ssv_pkg::ROLE_INT;
               t.kind = ssv_pkg::KIND_INT;
               fcount = fcount + 1;
               if (fcount >= 8) begin
                  fcount = 0;
                  next_value();
               end
            end
            default: begin
               // byte past a complete snapshot
               t.role = ssv_pkg::ROLE_IGNORED;
               kept = ssv_pkg::ST_TRAILING;
            end
         endcase
      end

      if (lst) begin
         if (kept != ssv_pkg::ST_PENDING) begin
            t.status = kept;
         end else begin
            // unfinished payload reports the phase it stopped in
            case (ph)
               ssv_pkg::PH_DONE:  t.status = ssv_pkg::ST_OK;
               ssv_pkg::PH_MAGIC: t.status = ssv_pkg::ST_MAGIC;
               ssv_pkg::PH_COLS:  t.status = ssv_pkg::ST_COLS;
               ssv_pkg::PH_ROWS:  t.status = ssv_pkg::ST_ROWS;
               ssv_pkg::PH_KIND:  t.status = ssv_pkg::ST_KIND;
               default:           t.status = ssv_pkg::ST_VALUE;
            endcase
         end
         clear_parser();
      end else begin
         t.status = kept;
      end
      return t;
   endfunction

   function automatic void report_mismatch(input string what, input byte_tag_type e,
                                           input byte_tag_type g);
      if (mismatches < 10) begin
         $display("%t %s: expected role %0d kind %0d col %0d row %0d status %0d,",
                  $time, what, e.role, e.kind, e.column, e.row, e.status);
         $display("   got role %0d kind %0d col %0d row %0d status %0d",
                  g.role, g.kind, g.column, g.row, g.status);
      end
      mismatches = mismatches + 1;
   endfunction

   // ---------------------------------------------------------------- monitor

   // one sampling point per edge: predict accepted bytes, then check accepted responses
   always @(posedge clock) begin
      byte_tag_type want, got;
      if (reset) begin
         clear_parser();
         cfg_columns = ssv_pkg::COLS_RESET;
         quiet_cycles = 0;
      end else begin
         if (csr_valid && csr_ready) cfg_columns = csr_expected_columns;
         if (req_valid && req_ready) begin
            want = tag_byte(req_data_byte, req_last_byte);
            expected_tags = {expected_tags, want};
            // every accepted byte counts toward the stimulus budget
            accepted_bytes = accepted_bytes + 1;
         end
         if (rsp_valid && rsp_ready) begin
            got = {rsp_byte_role, rsp_value_kind, rsp_column_index, rsp_row_index, rsp_status};
            if (expected_tags.size() == 0) begin
               report_mismatch("unexpected response", '0, got);
            end else begin
               want = expected_tags.pop_front();
               if (got !== want) report_mismatch("response mismatch", want, got);
            end
         end
         // watchdog on cycles without any transaction
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles = quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("snapshot_stream_validator_unit_tb: done, errors");
            $finish;
         end
      end
   end

   // receiver backpressure in random bursts
   always begin
      @(negedge clock);
      if (receiver_stalls && $urandom_range(0, 7) == 0) begin
         rsp_ready <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      rsp_ready <= 1'b1;
   end

   // ---------------------------------------------------------------- stimulus helpers

   // entered and left at a falling edge; valid stays up for a following byte
   task automatic send_byte(input logic [7:0] b, input logic lst);
      if (sender_idles && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= lst;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_payload();
      for (int i = 0; i < payload.size(); i++)
         send_byte(payload[i], i == payload.size() - 1);
      payload.delete();
   endtask

   // drop the request and drain every response
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_tags.size() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_expected_columns(input logic [8:0] v);
      wait_idle();
      csr_valid <= 1'b1;
      csr_expected_columns <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic void append_byte(input logic [7:0] b);
      payload = {payload, b};
   endfunction

   function automatic void add_word(input logic [31:0] w);
      for (int k = 0; k < 4; k++) append_byte(w[8 * k +: 8]);
   endfunction

   function automatic void start_payload(input logic [31:0] cols, input logic [31:0] rows);
      payload.delete();
      add_word(ssv_pkg::MAGIC_WORD);
      add_word(cols);
      add_word(rows);
   endfunction

   // one value with random content; a bad real gets an all-ones exponent
   function automatic void add_value(input logic [1:0] kind, input bit bad_real);
      logic [7:0] b;
      int unsigned len;
      append_byte(8'(kind));
      case (kind)
         ssv_pkg::KIND_NULL: ;
         ssv_pkg::KIND_TEXT: begin
            len = $urandom_range(0, 5);
            add_word(len);
            repeat (len) append_byte(8'($urandom));
         end
         default: begin
            for (int k = 0; k < 8; k++) begin
               b = 8'($urandom);
               if (kind == ssv_pkg::KIND_REAL && bad_real && k == 6) b[7:4] = 4'hF;
               if (kind == ssv_pkg::KIND_REAL && bad_real && k == 7) b[6:0] = 7'h7F;
               append_byte(b);
            end
         end
      endcase
   endfunction

   // ---------------------------------------------------------------- tests

   // magic failure, empty snapshot and a trailing byte, at the reset column count
   task automatic test_magic_and_trailing();
      payload.delete();
      append_byte(8'hFF);
      send_payload();
      start_payload(32'(ssv_pkg::COLS_RESET), 0);
      send_payload();
      start_payload(32'(ssv_pkg::COLS_RESET), 0);
      append_byte(8'h00);
      send_payload();
   endtask

   // register at its limits, inside and outside the legal range
   task automatic test_column_register();
      write_expected_columns(9'd256);
      start_payload(256, 0);
      send_payload();
      write_expected_columns(9'd0);
      start_payload(0, 1);
      send_payload();
      write_expected_columns(9'h1FF);
      start_payload(32'h1FF, 1);
      send_payload();
      write_expected_columns(9'd1);
      start_payload(1, 1);
      add_value(ssv_pkg::KIND_INT, 1'b0);
      send_payload();
   endtask

   // row limits, bad kind, oversized text, non-finite real and every kind once
   task automatic test_value_errors();
      write_expected_columns(9'd1);
      start_payload(1, MAX_ROWS + 1);
      send_payload();
      start_payload(1, 32'hFFFF_FFFF);
      send_payload();
      start_payload(1, MAX_ROWS);
      add_value(ssv_pkg::KIND_NULL, 1'b0);
      send_payload();
      start_payload(1, 1);
      append_byte(8'h04);
      send_payload();
      start_payload(1, 1);
      append_byte(8'(ssv_pkg::KIND_TEXT));
      add_word(32'hFFFF_FFFF);
      repeat (3) append_byte(8'($urandom));
      send_payload();
      start_payload(1, 1);
      add_value(ssv_pkg::KIND_REAL, 1'b1);
      send_payload();
      start_payload(1, 4);
      add_value(ssv_pkg::KIND_NULL, 1'b0);
      add_value(ssv_pkg::KIND_TEXT, 1'b0);
      add_value(ssv_pkg::KIND_REAL, 1'b0);
      add_value(ssv_pkg::KIND_INT, 1'b0);
      send_payload();
   endtask

   // well-formed snapshots with random values, mixed with broken and noisy payloads
   task automatic test_random_snapshots(input int unsigned budget, input logic [8:0] cols);
      int unsigned target, rows, mode, cut;
      logic [31:0] hdr_cols;
      write_expected_columns(cols);
      target = accepted_bytes + budget;
      while (accepted_bytes < target) begin
         rows = $urandom_range(0, 3);
         mode = $urandom_range(0, 11);
         hdr_cols = 32'(cols);
         if (mode == 8) hdr_cols = hdr_cols ^ (32'd1 << $urandom_range(0, 31));
         start_payload(hdr_cols, rows);
         repeat (rows * cols) add_value(2'($urandom_range(0, 3)), $urandom_range(0, 5) == 0);
         case (mode)
            6: begin
               // cut short at any point
               cut = $urandom_range(1, payload.size());
               payload = payload[0:cut - 1];
            end
            7: payload[$urandom_range(0, payload.size() - 1)] = 8'($urandom);
            9: repeat ($urandom_range(1, 3)) append_byte(8'($urandom));
            10: begin
               payload.delete();
               repeat ($urandom_range(1, 8)) append_byte(8'($urandom));
            end
            11: if (payload.size() > 12) payload[12] = 8'($urandom_range(4, 255));
            default: ;
         endcase
         send_payload();
      end
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_magic_and_trailing();
      test_column_register();
      test_value_errors();
      repeat (3) test_random_snapshots(45, 9'($urandom_range(1, 6)));

      // back-to-back traffic with no idling on either side
      wait_idle();
      sender_idles = 1'b0;
      receiver_stalls = 1'b0;
      test_random_snapshots(40, 9'd2);

      wait_idle();
      if (mismatches == 0 && expected_tags.size() == 0)
         $display("snapshot_stream_validator_unit_tb: done, clean");
      else
         $display("snapshot_stream_validator_unit_tb: done, errors");
      $finish;
   end

endmodule
